FILE: design/keypress_power_down_sequencer_core_defines.svh
// ----------------------------------------------------------------------------
// keypress power-down sequencer assertion macros
// concurrent assertion wrappers clocked on clk_i; KPDS_ASSERT is gated by rst_ni, KPDS_ASSERT_ALWAYS is not
// ----------------------------------------------------------------------------
`ifndef KEYPRESS_POWER_DOWN_SEQUENCER_CORE_DEFINES_SVH
`define KEYPRESS_POWER_DOWN_SEQUENCER_CORE_DEFINES_SVH

// checked only while out of reset
`define KPDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define KPDS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: design/kpds_pkg.sv
// ----------------------------------------------------------------------------
// kpds_pkg
// shared types and constants of the keypress power-down sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package kpds_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned DurW   = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 3;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_START_SETTLE   = 3'd0,
    REG_PREFIX_HOLD    = 3'd1,
    REG_PREFIX_SETTLE  = 3'd2,
    REG_ON_HOLD        = 3'd3,
    REG_OFF_TIMEOUT    = 3'd4,
    REG_OFF_STABLE     = 3'd5,
    REG_CONFIRM_VIS    = 3'd6,
    REG_MAX_ATTEMPTS   = 3'd7
  } cfg_reg_e;

  // reset values
  localparam logic [DurW-1:0]   RstStartSettle  = 16'd250;
  localparam logic [DurW-1:0]   RstPrefixHold   = 16'd180;
  localparam logic [DurW-1:0]   RstPrefixSettle = 16'd300;
  localparam logic [DurW-1:0]   RstOnHold       = 16'd220;
  localparam logic [DurW-1:0]   RstOffTimeout   = 16'd6000;
  localparam logic [DurW-1:0]   RstOffStable    = 16'd0;
  localparam logic [DurW-1:0]   RstConfirmVis   = 16'd0;
  localparam logic [CountW-1:0] RstMaxAttempts  = 8'd3;

  typedef struct packed {
    logic [DurW-1:0]   start_settle;
    logic [DurW-1:0]   prefix_hold;
    logic [DurW-1:0]   prefix_settle;
    logic [DurW-1:0]   on_hold;
    logic [DurW-1:0]   off_timeout;
    logic [DurW-1:0]   off_stable;
    logic [DurW-1:0]   confirm_vis;
    logic [CountW-1:0] max_attempts;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_RESET = 2'd0,
    OP_START = 2'd1,
    OP_POLL  = 2'd2
  } opcode_e;

  typedef enum logic [3:0] {
    ACT_NONE        = 4'd0,
    ACT_PRESS_PF    = 4'd1,
    ACT_REL_PF      = 4'd2,
    ACT_PRESS_ON    = 4'd3,
    ACT_REL_ON      = 4'd4,
    ACT_OFF_SEEN    = 4'd5,
    ACT_REAWAKE     = 4'd6,
    ACT_CONFIRMED   = 4'd7,
    ACT_REQ_OFF     = 4'd8,
    ACT_REQ_OFF_UNC = 4'd9,
    ACT_FAILED      = 4'd10
  } action_e;

endpackage

`default_nettype wire

FILE: design/keypress_power_down_sequencer_core.sv
// ----------------------------------------------------------------------------
// keypress_power_down_sequencer_core: timed prefix/on key power-down sequencer
// latency: a result is valid the cycle after its request is accepted
// throughput: one request per cycle while results are taken, set by the single stage state update
// reset: sequence idle, counters and time targets zero, registers at defaults
// ----------------------------------------------------------------------------
`default_nettype none

`include "keypress_power_down_sequencer_core_defines.svh"

module keypress_power_down_sequencer_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic [kpds_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [kpds_pkg::DurW-1:0]    cfg_wdata_i,
  // event requests
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   opcode_i,
  input  wire logic [kpds_pkg::TimeW-1:0]   now_time_i,
  input  wire logic                         display_on_i,
  // results
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [3:0]                        action_o,
  output logic                              active_o,
  output logic [kpds_pkg::CountW-1:0]       attempt_count_o
);
  import kpds_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_PRESS_PF = 4'd1;
  localparam logic [3:0] ST_REL_PF   = 4'd2;
  localparam logic [3:0] ST_PRESS_ON = 4'd3;
  localparam logic [3:0] ST_REL_ON   = 4'd4;
  localparam logic [3:0] ST_WAIT_OFF = 4'd5;
  localparam logic [3:0] ST_VERIFY   = 4'd6;
  localparam logic [3:0] ST_CONFIRM  = 4'd7;
  localparam logic [3:0] ST_FINISHED = 4'd8;
  localparam logic [3:0] ST_FAILED   = 4'd9;

  cfg_t cfg;

  kpds_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  logic [3:0]        stage_q, stage_d;
  logic [CountW-1:0] att_q, att_d;
  logic [TimeW-1:0]  next_q, next_d;
  logic [TimeW-1:0]  dl_q, dl_d;

  logic              out_valid_q;
  action_e           action_q, action_d;
  logic              active_q;
  logic [CountW-1:0] att_out_q;

  logic              accept;
  logic [DurW-1:0]   addend;
  logic [TimeW-1:0]  sum;
  logic [TimeW-1:0]  next_diff, dl_diff;
  logic              next_reached, dl_reached;
  logic              at_limit;
  logic              active_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // wrap-safe time compare: target reached when now - target is not negative
  assign next_diff    = now_time_i - next_q;
  assign dl_diff      = now_time_i - dl_q;
  assign next_reached = !next_diff[TimeW-1];
  assign dl_reached   = !dl_diff[TimeW-1];
  assign at_limit     = att_q >= cfg.max_attempts;

  // one shared adder; the duration depends on which transition fires
  always_comb begin
    addend = '0;
    if (opcode_i == OP_START) begin
      addend = cfg.start_settle;
    end else begin
      unique case (stage_q)
        ST_PRESS_PF: addend = cfg.prefix_hold;
        ST_REL_PF:   addend = cfg.prefix_settle;
        ST_PRESS_ON: addend = cfg.on_hold;
        ST_REL_ON:   addend = cfg.off_timeout;
        ST_WAIT_OFF: addend = display_on_i ? cfg.prefix_hold : cfg.off_stable;
        ST_VERIFY:   addend = display_on_i ? cfg.start_settle : cfg.confirm_vis;
        ST_CONFIRM:  addend = cfg.start_settle;
        default:     addend = '0;
      endcase
    end
  end

  assign sum = now_time_i + {{(TimeW-DurW){1'b0}}, addend};

  always_comb begin
    stage_d  = stage_q;
    att_d    = att_q;
    next_d   = next_q;
    dl_d     = dl_q;
    action_d = ACT_NONE;
    unique case (opcode_i)
      OP_RESET: begin
        stage_d = ST_IDLE;
        att_d   = '0;
        next_d  = '0;
        dl_d    = '0;
      end
      OP_START: begin
        stage_d = ST_PRESS_PF;
        att_d   = CountW'(1);
        next_d  = sum;
        dl_d    = '0;
      end
      OP_POLL: begin
        unique case (stage_q)
          ST_WAIT_OFF: begin
            if (!display_on_i) begin
              stage_d  = ST_VERIFY;
              next_d   = sum;
              action_d = ACT_OFF_SEEN;
            end else if (dl_reached) begin
              if (at_limit) begin
                stage_d  = ST_FINISHED;
                action_d = ACT_REQ_OFF_UNC;
              end else begin
                // timeout retry goes straight to pressing the prefix key
                att_d    = att_q + CountW'(1);
                stage_d  = ST_REL_PF;
                next_d   = sum;
                action_d = ACT_PRESS_PF;
              end
            end
          end
          ST_VERIFY, ST_CONFIRM: begin
            if (display_on_i) begin
              if (at_limit) begin
                stage_d  = ST_FINISHED;
                action_d = ACT_REQ_OFF_UNC;
              end else begin
                att_d    = att_q + CountW'(1);
                stage_d  = ST_PRESS_PF;
                next_d   = sum;
                action_d = ACT_REAWAKE;
              end
            end else if (next_reached) begin
              if (stage_q == ST_VERIFY) begin
                stage_d  = ST_CONFIRM;
                next_d   = sum;
                action_d = ACT_CONFIRMED;
              end else begin
                stage_d  = ST_FINISHED;
                action_d = ACT_REQ_OFF;
              end
            end
          end
          ST_PRESS_PF: begin
            if (next_reached) begin
              stage_d  = ST_REL_PF;
              next_d   = sum;
              action_d = ACT_PRESS_PF;
            end
          end
          ST_REL_PF: begin
            if (next_reached) begin
              stage_d  = ST_PRESS_ON;
              next_d   = sum;
              action_d = ACT_REL_PF;
            end
          end
          ST_PRESS_ON: begin
            if (next_reached) begin
              stage_d  = ST_REL_ON;
              next_d   = sum;
              action_d = ACT_PRESS_ON;
            end
          end
          ST_REL_ON: begin
            if (next_reached) begin
              stage_d  = ST_WAIT_OFF;
              dl_d     = sum;
              action_d = ACT_REL_ON;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign active_d = (stage_d != ST_IDLE) && (stage_d != ST_FINISHED) &&
                    (stage_d != ST_FAILED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= ST_IDLE;
      att_q       <= '0;
      next_q      <= '0;
      dl_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        stage_q <= stage_d;
        att_q   <= att_d;
        next_q  <= next_d;
        dl_q    <= dl_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q  <= action_d;
      active_q  <= active_d;
      att_out_q <= att_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign action_o        = action_q;
  assign active_o        = active_q;
  assign attempt_count_o = att_out_q;

  `KPDS_ASSERT(a_start_result,
    (in_valid_i && in_ready_o && opcode_i == OP_START) |=>
    (out_valid_o && action_o == ACT_NONE && active_o && attempt_count_o == CountW'(1)),
    "start request did not arm the sequence")
  `KPDS_ASSERT(a_held_result_blocks,
    (out_valid_o && !out_ready_i) |-> !in_ready_o,
    "request accepted while a result was still held")
  `KPDS_ASSERT_ALWAYS(a_no_failed_code,
    out_valid_o |-> (action_o != ACT_FAILED),
    "failure action code produced")

endmodule

`default_nettype wire

FILE: design/kpds_cfg.sv
// ----------------------------------------------------------------------------
// kpds_cfg
// configuration register file with plain indexed write port
// ----------------------------------------------------------------------------
`default_nettype none

module kpds_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [kpds_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [kpds_pkg::DurW-1:0]    cfg_wdata_i,
  output kpds_pkg::cfg_t                    cfg_o
);
  import kpds_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_settle  <= RstStartSettle;
      cfg_q.prefix_hold   <= RstPrefixHold;
      cfg_q.prefix_settle <= RstPrefixSettle;
      cfg_q.on_hold       <= RstOnHold;
      cfg_q.off_timeout   <= RstOffTimeout;
      cfg_q.off_stable    <= RstOffStable;
      cfg_q.confirm_vis   <= RstConfirmVis;
      cfg_q.max_attempts  <= RstMaxAttempts;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_START_SETTLE:  cfg_q.start_settle  <= cfg_wdata_i;
        REG_PREFIX_HOLD:   cfg_q.prefix_hold   <= cfg_wdata_i;
        REG_PREFIX_SETTLE: cfg_q.prefix_settle <= cfg_wdata_i;
        REG_ON_HOLD:       cfg_q.on_hold       <= cfg_wdata_i;
        REG_OFF_TIMEOUT:   cfg_q.off_timeout   <= cfg_wdata_i;
        REG_OFF_STABLE:    cfg_q.off_stable    <= cfg_wdata_i;
        REG_CONFIRM_VIS:   cfg_q.confirm_vis   <= cfg_wdata_i;
        REG_MAX_ATTEMPTS:  cfg_q.max_attempts  <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire
